/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/dmed_pkg.sv */
// Package with shared types and constants of the disk morphology block.
`default_nettype none
package dmed_pkg;
  localparam int MaxWidth = 256;
  localparam int MaxHeight = 256;
  localparam int MaxDiameter = 63;
  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight);
  localparam int AddrW = RowW + ColW;

  localparam logic CmdStore = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic [2:0] RegWidth = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegDiameter = 3'd2;
  localparam logic [2:0] RegMode = 3'd3;
  localparam logic [2:0] RegErode = 3'd4;
  localparam logic [2:0] RegDilate = 3'd5;

  // One classified job handed from the front to the back.
  typedef struct packed {
    logic        query;
    logic        outside;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] pixel;
  } job_t;
endpackage
`default_nettype wire

/* rtl/dmed_front.sv */
// Front end: accepts input words, classifies them and queues them as jobs.
`default_nettype none
module dmed_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             command,
  input  wire logic [7:0]       row,
  input  wire logic [7:0]       col,
  input  wire logic [15:0]      pixel_value,
  input  wire logic [8:0]       eff_w,
  input  wire logic [8:0]       eff_h,
  output logic                  job_valid,
  input  wire logic             job_take,
  output dmed_pkg::job_t        job
);
  // Two-entry queue.
  dmed_pkg::job_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  dmed_pkg::job_t cls;
  logic push, pop;

  // Classify the incoming word against the frame size.
  always_comb begin
    cls.query = (command == dmed_pkg::CmdQuery);
    cls.outside = ({1'b0, row} >= eff_h) || ({1'b0, col} >= eff_w);
    cls.row = row;
    cls.col = col;
    cls.pixel = pixel_value;
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign job_valid = (count != 2'd0);
  assign pop = job_valid && job_take;
  assign job = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* rtl/dmed_back.sv */
// Back end: frame memory, window scan and min/max accumulation.
`default_nettype none
module dmed_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             job_valid,
  output logic                  job_take,
  input  dmed_pkg::job_t        job,
  input  wire logic [8:0]       eff_w,
  input  wire logic [8:0]       eff_h,
  input  wire logic [5:0]       diam,
  input  wire logic             dilate,
  input  wire logic [15:0]      start_val,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output logic [15:0]           res_value,
  output logic                  res_oof,
  output logic                  busy
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_OUT} state_t;
  state_t state;

  logic [15:0] mem [dmed_pkg::MaxWidth * dmed_pkg::MaxHeight];
  logic [15:0] rd_data;
  logic [dmed_pkg::AddrW-1:0] rd_addr;

  logic [7:0] qrow, qcol;
  logic [5:0] d, wi, wj;
  logic [5:0] half;
  logic signed [15:0] acc;
  // Pipeline tags of the registered frame-memory read.
  logic p_valid, p_use_mem;
  // A result word is loaded into the output register this cycle.
  logic res_load;

  // Window cell position and disk test.
  logic signed [10:0] r_s, c_s;
  logic signed [14:0] dy, dx;
  logic [14:0] dist2;
  logic [14:0] d2;
  logic in_disk, in_frame, last_cell;

  always_comb begin
    half = d >> 1;
    r_s = $signed({3'b0, qrow}) + $signed({5'b0, wi}) - $signed({5'b0, half});
    c_s = $signed({3'b0, qcol}) + $signed({5'b0, wj}) - $signed({5'b0, half});
    dy = $signed({8'b0, wi, 1'b1}) - $signed({9'b0, d});
    dx = $signed({8'b0, wj, 1'b1}) - $signed({9'b0, d});
    dist2 = $unsigned(dy * dy) + $unsigned(dx * dx);
    d2 = {9'b0, d} * {9'b0, d};
    in_disk = dist2 < d2;
    in_frame = (r_s >= 0) && (r_s < $signed({2'b0, eff_h})) &&
               (c_s >= 0) && (c_s < $signed({2'b0, eff_w}));
    rd_addr = {r_s[dmed_pkg::RowW-1:0], c_s[dmed_pkg::ColW-1:0]};
    last_cell = (wi == d - 6'd1) && (wj == d - 6'd1);
  end

  assign job_take = (state == S_IDLE) && job_valid && (!res_valid || res_ready);
  assign busy = (state != S_IDLE) || res_valid;
  assign res_load = (job_take && job.query && (job.outside || (diam == 6'd0))) ||
                    ((state == S_OUT) && !res_valid);

  // Memory write on store jobs, registered read during the scan.
  always_ff @(posedge clk) begin
    if (job_take && !job.query && !job.outside)
      mem[{job.row, job.col}] <= job.pixel;
    rd_data <= mem[rd_addr];
  end

  // Value of the cell read in the previous cycle.
  logic signed [15:0] v;
  assign v = p_use_mem ? $signed(rd_data) : 16'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      if (res_load) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
      // Fold in the cell read last cycle.
      if (p_valid) begin
        if (dilate ? (v > acc) : (v < acc)) acc <= v;
      end
      case (state)
        S_IDLE: begin
          p_valid <= 1'b0;
          if (job_take && job.query) begin
            if (job.outside) begin
              res_value <= 16'd0;
              res_oof <= 1'b1;
            end else if (diam == 6'd0) begin
              res_value <= start_val;
              res_oof <= 1'b0;
            end else begin
              qrow <= job.row;
              qcol <= job.col;
              d <= diam;
              wi <= 6'd0;
              wj <= 6'd0;
              acc <= start_val;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          p_valid <= in_disk;
          p_use_mem <= in_frame;
          if (last_cell) state <= S_DRAIN;
          else if (wj == d - 6'd1) begin
            wj <= 6'd0;
            wi <= wi + 6'd1;
          end else wj <= wj + 6'd1;
        end
        S_DRAIN: begin
          p_valid <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid) begin
            res_value <= acc;
            res_oof <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/disk_morphology_erode_dilate.sv */
// Top level of the disk-element grayscale erosion and dilation block.
// Input words on s_axis carry store or query commands; results leave on
// m_axis, one word per query and none per store. Configuration is written
// through cfg_valid/cfg_ready with cfg_index and cfg_data; the user must
// write it only while idle, which the block itself does not enforce. The
// back end writes a store to the frame memory as it takes the job. A query
// inside the frame scans the whole D by D window, one frame-memory read per
// cycle; the result passes the scan, drain and output states, and only then
// does the back end take its next word. Out-of-frame queries and zero
// diameter load their result as the back end takes them. The per-cell
// frame memory read sets the rate. A two-word queue sits between the input
// and the back end, so up to two input words are taken while a result
// waits; then s_axis_tready drops. The result register holds its word while
// m_axis_tready is low. Reset clears control state and restores register
// defaults; frame contents are undefined until written.
`default_nettype none
`include "assert_macros.svh"
module disk_morphology_erode_dilate (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: row[7:0], col[15:8], pixel_value[31:16]
  input  wire logic [31:0] s_axis_tdata,
  // tuser: command[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: result_value[15:0]
  output logic [15:0]      m_axis_tdata,
  // tuser: out_of_frame[0]
  output logic             m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic [8:0] img_w, img_h, eff_w, eff_h;
  logic [5:0] diam;
  logic mode;
  logic [15:0] erode_start, dilate_start;
  logic job_valid, job_take, busy;
  logic res_stall;
  dmed_pkg::job_t job;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= 9'd256;
      img_h <= 9'd256;
      diam <= 6'd25;
      mode <= 1'b0;
      erode_start <= 16'd256;
      dilate_start <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dmed_pkg::RegWidth: img_w <= cfg_data[8:0];
        dmed_pkg::RegHeight: img_h <= cfg_data[8:0];
        dmed_pkg::RegDiameter: diam <= cfg_data[5:0];
        dmed_pkg::RegMode: mode <= cfg_data[0];
        dmed_pkg::RegErode: erode_start <= cfg_data;
        dmed_pkg::RegDilate: dilate_start <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate frame dimensions to the memory size.
  assign eff_w = (img_w > 9'(dmed_pkg::MaxWidth)) ? 9'(dmed_pkg::MaxWidth) : img_w;
  assign eff_h = (img_h > 9'(dmed_pkg::MaxHeight)) ? 9'(dmed_pkg::MaxHeight) : img_h;

  dmed_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .command(s_axis_tuser), .row(s_axis_tdata[7:0]), .col(s_axis_tdata[15:8]),
    .pixel_value(s_axis_tdata[31:16]),
    .eff_w, .eff_h, .job_valid, .job_take, .job
  );

  dmed_back u_back (
    .clk, .rst, .job_valid, .job_take, .job, .eff_w, .eff_h, .diam,
    .dilate(mode), .start_val(mode ? dilate_start : erode_start),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_value(m_axis_tdata), .res_oof(m_axis_tuser), .busy
  );

  // A result word waiting on the receiver.
  assign res_stall = m_axis_tvalid && !m_axis_tready;

  `ASSERT_IMPLY(a_oof_zero, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "oof data")
  `ASSERT_IMPLY(a_take_idle, clk, rst, job_take, job_valid, "job taken from empty queue")
  `ASSERT_NEXT(a_res_hold, clk, rst, res_stall, m_axis_tvalid && $stable(m_axis_tdata), "held")
  `ASSERT_IMPLY(a_cfg_idle, clk, rst, cfg_valid, !busy && !job_valid, "cfg while busy")
endmodule
`default_nettype wire
